### rtl/gqls_pkg.sv
// Shared types, widths and constants of the grid Q-learning step block.
`default_nettype none
package gqls_pkg;

	localparam int ROW_W      = 4;
	localparam int COL_W      = 3;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int OUT_Q_W    = 16;
	localparam int RATE_W     = 8;
	localparam int REWARD_W   = 16;
	localparam int WALL_BITS  = 54;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 54;

	localparam logic [WALL_BITS-1:0]       WALL_RESET   = 54'd132094011568800;
	localparam logic [ROW_W-1:0]           GOAL_ROW_RST = 4'd3;
	localparam logic [COL_W-1:0]           GOAL_COL_RST = 3'd2;
	localparam logic [RATE_W-1:0]          LEARN_RST    = 8'd128;
	localparam logic [RATE_W-1:0]          DISCOUNT_RST = 8'd179;
	localparam logic signed [REWARD_W-1:0] REWARD_RST   = -16'sd256;

	typedef enum logic [ACT_W-1:0] {
		ACT_UP    = 2'd0,
		ACT_DOWN  = 2'd1,
		ACT_LEFT  = 2'd2,
		ACT_RIGHT = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_MOVED   = 2'd0,
		ST_BOXED   = 2'd1,
		ST_AT_GOAL = 2'd2,
		ST_RESTART = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WALL_MAP    = 3'd0,
		CFG_GOAL_ROW    = 3'd1,
		CFG_GOAL_COL    = 3'd2,
		CFG_LEARN_RATE  = 3'd3,
		CFG_DISCOUNT    = 3'd4,
		CFG_STEP_REWARD = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_CUR,
		S_MOVE,
		S_SCAN_TGT,
		S_CALC,
		S_WAIT,
		S_DONE
	} fsm_t;

endpackage
`default_nettype wire

### rtl/gqls_if.sv
// Handshake channel interfaces: command input, result output and register writes.
`default_nettype none
interface gqls_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [gqls_pkg::ROW_W-1:0]    start_row;
	logic [gqls_pkg::COL_W-1:0]    start_col;

	modport source(output valid, command, start_row, start_col, input ready);
	modport sink(input valid, command, start_row, start_col, output ready);
endinterface

interface gqls_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [gqls_pkg::ACT_W-1:0]           action;
	logic [gqls_pkg::ROW_W-1:0]           new_row;
	logic [gqls_pkg::COL_W-1:0]           new_col;
	logic signed [gqls_pkg::OUT_Q_W-1:0]  new_q;
	logic [gqls_pkg::STAT_W-1:0]          status;
	logic                                 reached_goal;

	modport source(output valid, action, new_row, new_col, new_q, status, reached_goal,
		input ready);
	modport sink(input valid, action, new_row, new_col, new_q, status, reached_goal,
		output ready);
endinterface

interface gqls_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [gqls_pkg::CFG_IDX_W-1:0]     idx;
	logic [gqls_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface
`default_nettype wire

### rtl/gqls_qmem.sv
// Q table memory: one write and one registered read port, entries read as zero until written.
`default_nettype none
module gqls_qmem #(
	parameter int DEPTH = 216,
	parameter int AW    = 8,
	parameter int QW    = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr,
	output logic signed [QW-1:0]      rd_data,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire logic signed [QW-1:0] wr_data
);

	logic signed [QW-1:0] mem [DEPTH];
	logic [DEPTH-1:0]     written_q;
	logic signed [QW-1:0] rd_raw_q;
	logic                 rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// An entry that was never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : '0;

endmodule
`default_nettype wire

### rtl/gqls_upd.sv
// Q update datapath: discounted target, temporal difference and scaled, saturated sum.
`default_nettype none
module gqls_upd #(
	parameter int QW = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic signed [QW-1:0]                   tmax,
	input  wire logic signed [QW-1:0]                   q_old,
	input  wire logic [gqls_pkg::RATE_W-1:0]            learn_rate,
	input  wire logic [gqls_pkg::RATE_W-1:0]            discount,
	input  wire logic signed [gqls_pkg::REWARD_W-1:0]   step_reward,
	output logic                                        done,
	output logic signed [QW-1:0]                        q_new
);

	localparam int P1W = QW + gqls_pkg::RATE_W + 1;
	localparam int DSW = QW + 1;
	localparam int DW  = ((DSW > gqls_pkg::REWARD_W) ? DSW : gqls_pkg::REWARD_W) + 2;
	localparam int P2W = DW + gqls_pkg::RATE_W + 1;
	localparam int SW  = DW + 2;

	logic                  vld_s1, vld_s2;
	logic signed [P1W-1:0] dprod_s1;
	logic signed [QW-1:0]  q_s1, q_s2;
	logic signed [P2W-1:0] lprod_s2;
	logic signed [DSW-1:0] disc;
	logic signed [DW-1:0]  diff;
	logic signed [SW-1:0]  sum;
	logic                  ovf;

	// Arithmetic shifts right by eight give the floor of a division by 256.
	assign disc = DSW'(dprod_s1 >>> 8);
	assign diff = DW'(step_reward) + DW'(disc) - DW'(q_s1);
	assign sum  = SW'(q_s2) + SW'(lprod_s2 >>> 8);
	assign ovf  = !((&sum[SW-1:QW-1]) || !(|sum[SW-1:QW-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dprod_s1 <= $signed({1'b0, discount}) * tmax;
		q_s1     <= q_old;
		lprod_s2 <= $signed({1'b0, learn_rate}) * diff;
		q_s2     <= q_s1;
	end

	assign done  = vld_s2;
	assign q_new = ovf ? (sum[SW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}})
		: sum[QW-1:0];

endmodule
`default_nettype wire

### rtl/grid_q_learning_step.sv
// Greedy tabular Q-learning step on a walled grid, Q table held in one memory.
// Restart, at-goal and boxed-in commands go straight to the done state, which loads the
// output register once it is free; the block then returns to idle for the next command.
// Learning step: a scan of the current cell's four Q entries, a move, a scan of the target
// cell's four entries on the single Q table read port, then the update pipeline and write.
// The next command is accepted while the previous result still waits in the output register.
// Reset clears the agent to row 0, column 0, loads the register defaults and marks every
// Q entry as zero at once; a command is taken in the first cycle after reset.
`default_nettype none
module grid_q_learning_step #(
	parameter int ROWS    = 9,
	parameter int COLS    = 6,
	parameter int Q_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	gqls_cmd_if.sink           cmd,
	gqls_res_if.source         res,
	gqls_cfg_if.sink           cfg
);

	localparam int NCELLS   = ROWS * COLS;
	localparam int CELL_W   = $clog2(NCELLS);
	localparam int CELL_PAD = 2 ** CELL_W;
	localparam int DEPTH    = NCELLS * 4;
	localparam int QA_W     = CELL_W + 2;
	localparam int RW       = gqls_pkg::ROW_W;
	localparam int CW       = gqls_pkg::COL_W;
	localparam int OQW      = gqls_pkg::OUT_Q_W;

	// Configuration registers.
	logic [gqls_pkg::WALL_BITS-1:0]       wall_map_q;
	logic [RW-1:0]                        goal_row_q;
	logic [CW-1:0]                        goal_col_q;
	logic [gqls_pkg::RATE_W-1:0]          learn_rate_q;
	logic [gqls_pkg::RATE_W-1:0]          discount_q;
	logic signed [gqls_pkg::REWARD_W-1:0] step_reward_q;

	gqls_pkg::fsm_t    state_q, state_d;
	logic              cmd_ready, upd_start, res_load;

	logic [2:0]        cnt_q;
	logic [3:0]        acts_q, tacts_q;
	logic [RW-1:0]     agent_row_q, tgt_row_q, mv_row, row_sat;
	logic [CW-1:0]     agent_col_q, tgt_col_q, mv_col, col_sat;
	logic              scan_have_q;
	logic signed [Q_WIDTH-1:0] scan_max_q, best_qv_q, tmax;
	gqls_pkg::action_t scan_arg_q, best_a_q, dat_a;

	gqls_pkg::action_t pend_action_q;
	logic signed [OQW-1:0] pend_q_q;
	gqls_pkg::status_t pend_status_q;

	logic              res_valid_q, res_goal_q;
	gqls_pkg::action_t res_action_q;
	logic [RW-1:0]     res_row_q;
	logic [CW-1:0]     res_col_q;
	logic signed [OQW-1:0] res_newq_q;
	gqls_pkg::status_t res_status_q;

	logic [CELL_PAD-1:0] wall_pad;
	logic [3:0]          cur_acts, tgt_acts_d, scan_acts;
	logic                at_goal, cmd_fire, scanning, take;
	logic [CELL_W-1:0]   cur_cell, scan_cell;
	logic                rd_en, wr_en;
	logic [QA_W-1:0]     rd_addr, wr_addr;
	logic signed [Q_WIDTH-1:0] rd_q, upd_q;
	logic                upd_done;
	logic signed [Q_WIDTH+OQW-1:0] upd_q_ext;

	function automatic logic [CELL_W-1:0] cell_idx(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		return CELL_W'(int'(r) * COLS + int'(c));
	endfunction

	// Open neighbors in the order up, down, left, right.
	function automatic logic [3:0] valid_acts(input logic [RW-1:0] r, input logic [CW-1:0] c,
		input logic [CELL_PAD-1:0] w);
		logic [3:0] v;
		v[gqls_pkg::ACT_UP]    = (r != '0) && !w[cell_idx(r - 1'b1, c)];
		v[gqls_pkg::ACT_DOWN]  = ((RW + 1)'(r) + 1'b1 < (RW + 1)'(ROWS))
			&& !w[cell_idx(r + 1'b1, c)];
		v[gqls_pkg::ACT_LEFT]  = (c != '0) && !w[cell_idx(r, c - 1'b1)];
		v[gqls_pkg::ACT_RIGHT] = ((CW + 1)'(c) + 1'b1 < (CW + 1)'(COLS))
			&& !w[cell_idx(r, c + 1'b1)];
		return v;
	endfunction

	// Cells past the end of the wall register are never walls.
	for (genvar i = 0; i < CELL_PAD; i++) begin : g_wall
		if (i < NCELLS && i < gqls_pkg::WALL_BITS) begin : g_bit
			assign wall_pad[i] = wall_map_q[i];
		end else begin : g_none
			assign wall_pad[i] = 1'b0;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q    <= gqls_pkg::WALL_RESET;
			goal_row_q    <= gqls_pkg::GOAL_ROW_RST;
			goal_col_q    <= gqls_pkg::GOAL_COL_RST;
			learn_rate_q  <= gqls_pkg::LEARN_RST;
			discount_q    <= gqls_pkg::DISCOUNT_RST;
			step_reward_q <= gqls_pkg::REWARD_RST;
		end else if (cfg.valid) begin
			unique case (gqls_pkg::cfg_reg_t'(cfg.idx))
				gqls_pkg::CFG_WALL_MAP:    wall_map_q    <= cfg.data[gqls_pkg::WALL_BITS-1:0];
				gqls_pkg::CFG_GOAL_ROW:    goal_row_q    <= cfg.data[RW-1:0];
				gqls_pkg::CFG_GOAL_COL:    goal_col_q    <= cfg.data[CW-1:0];
				gqls_pkg::CFG_LEARN_RATE:  learn_rate_q  <= cfg.data[gqls_pkg::RATE_W-1:0];
				gqls_pkg::CFG_DISCOUNT:    discount_q    <= cfg.data[gqls_pkg::RATE_W-1:0];
				gqls_pkg::CFG_STEP_REWARD: step_reward_q <= $signed(
					cfg.data[gqls_pkg::REWARD_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cur_cell  = cell_idx(agent_row_q, agent_col_q);
	assign cur_acts  = valid_acts(agent_row_q, agent_col_q, wall_pad);
	assign at_goal   = (agent_row_q == goal_row_q) && (agent_col_q == goal_col_q);
	assign cmd_fire  = cmd.valid && cmd_ready;
	assign cmd.ready = cmd_ready;

	assign row_sat = (cmd.start_row >= RW'(ROWS)) ? RW'(ROWS - 1) : cmd.start_row;
	assign col_sat = (cmd.start_col >= CW'(COLS)) ? CW'(COLS - 1) : cmd.start_col;

	// Both scans share the read port: one read issued per cycle, its data compared in the next cycle.
	assign scanning  = (state_q == gqls_pkg::S_SCAN_CUR) || (state_q == gqls_pkg::S_SCAN_TGT);
	assign scan_cell = (state_q == gqls_pkg::S_SCAN_TGT) ? cell_idx(tgt_row_q, tgt_col_q)
		: cur_cell;
	assign scan_acts = (state_q == gqls_pkg::S_SCAN_TGT) ? tacts_q : acts_q;
	assign rd_en     = scanning && !cnt_q[2];
	assign rd_addr   = {scan_cell, cnt_q[1:0]};
	assign dat_a     = gqls_pkg::action_t'(cnt_q[1:0] - 2'd1);
	assign take      = scanning && (cnt_q != 3'd0) && scan_acts[dat_a]
		&& (!scan_have_q || (rd_q > scan_max_q));

	always_comb begin
		mv_row = agent_row_q;
		mv_col = agent_col_q;
		unique case (scan_arg_q)
			gqls_pkg::ACT_UP:    mv_row = agent_row_q - 1'b1;
			gqls_pkg::ACT_DOWN:  mv_row = agent_row_q + 1'b1;
			gqls_pkg::ACT_LEFT:  mv_col = agent_col_q - 1'b1;
			gqls_pkg::ACT_RIGHT: mv_col = agent_col_q + 1'b1;
			default: ;
		endcase
	end

	assign tgt_acts_d = valid_acts(mv_row, mv_col, wall_pad);
	assign tmax       = scan_have_q ? scan_max_q : '0;

	assign wr_en   = (state_q == gqls_pkg::S_WAIT) && upd_done;
	assign wr_addr = {cur_cell, best_a_q};

	gqls_qmem #(
		.DEPTH(DEPTH),
		.AW   (QA_W),
		.QW   (Q_WIDTH)
	) u_qmem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_q),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(upd_q)
	);

	gqls_upd #(
		.QW(Q_WIDTH)
	) u_upd (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (upd_start),
		.tmax       (tmax),
		.q_old      (best_qv_q),
		.learn_rate (learn_rate_q),
		.discount   (discount_q),
		.step_reward(step_reward_q),
		.done       (upd_done),
		.q_new      (upd_q)
	);

	assign upd_q_ext = (Q_WIDTH + OQW)'(upd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gqls_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		upd_start = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			gqls_pkg::S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd.valid) begin
					if (cmd.command || at_goal || (cur_acts == 4'd0)) begin
						state_d = gqls_pkg::S_DONE;
					end else begin
						state_d = gqls_pkg::S_SCAN_CUR;
					end
				end
			end
			gqls_pkg::S_SCAN_CUR: begin
				if (cnt_q[2]) begin
					state_d = gqls_pkg::S_MOVE;
				end
			end
			gqls_pkg::S_MOVE: state_d = gqls_pkg::S_SCAN_TGT;
			gqls_pkg::S_SCAN_TGT: begin
				if (cnt_q[2]) begin
					state_d = gqls_pkg::S_CALC;
				end
			end
			gqls_pkg::S_CALC: begin
				upd_start = 1'b1;
				state_d   = gqls_pkg::S_WAIT;
			end
			gqls_pkg::S_WAIT: begin
				if (upd_done) begin
					state_d = gqls_pkg::S_DONE;
				end
			end
			gqls_pkg::S_DONE: begin
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = gqls_pkg::S_IDLE;
				end
			end
			default: state_d = gqls_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			scan_have_q <= 1'b0;
			agent_row_q <= '0;
			agent_col_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			cnt_q <= (scanning && !cnt_q[2]) ? cnt_q + 3'd1 : 3'd0;
			if (state_q == gqls_pkg::S_IDLE || state_q == gqls_pkg::S_MOVE) begin
				scan_have_q <= 1'b0;
			end else if (take) begin
				scan_have_q <= 1'b1;
			end
			if (cmd_fire && cmd.command) begin
				agent_row_q <= row_sat;
				agent_col_q <= col_sat;
			end else if (wr_en) begin
				agent_row_q <= tgt_row_q;
				agent_col_q <= tgt_col_q;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gqls_pkg::S_IDLE) begin
			acts_q        <= cur_acts;
			pend_action_q <= gqls_pkg::ACT_UP;
			pend_q_q      <= '0;
			if (cmd.command) begin
				pend_status_q <= gqls_pkg::ST_RESTART;
			end else if (at_goal) begin
				pend_status_q <= gqls_pkg::ST_AT_GOAL;
			end else begin
				pend_status_q <= gqls_pkg::ST_BOXED;
			end
		end
		if (take) begin
			scan_max_q <= rd_q;
			scan_arg_q <= dat_a;
		end
		if (state_q == gqls_pkg::S_MOVE) begin
			tgt_row_q <= mv_row;
			tgt_col_q <= mv_col;
			tacts_q   <= tgt_acts_d;
			best_qv_q <= scan_max_q;
			best_a_q  <= scan_arg_q;
		end
		if (wr_en) begin
			pend_q_q      <= upd_q_ext[OQW-1:0];
			pend_action_q <= best_a_q;
			pend_status_q <= gqls_pkg::ST_MOVED;
		end
		if (res_load) begin
			res_action_q <= pend_action_q;
			res_row_q    <= agent_row_q;
			res_col_q    <= agent_col_q;
			res_newq_q   <= pend_q_q;
			res_status_q <= pend_status_q;
			res_goal_q   <= at_goal;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.action       = res_action_q;
	assign res.new_row      = res_row_q;
	assign res.new_col      = res_col_q;
	assign res.new_q        = res_newq_q;
	assign res.status       = res_status_q;
	assign res.reached_goal = res_goal_q;

endmodule
`default_nettype wire
